// ===== rtl/ecrt_pkg.sv =====
// ----------------------------------------------------------------------------
// ecrt_pkg
// Types, constants and controller codes shared by the encoder rpm tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ecrt_pkg;

    localparam int NUM_MOTORS  = 4;
    localparam int COUNT_BITS  = 16;
    localparam int MOTOR_BITS  = 2;
    localparam int CPR_BITS    = 16;
    localparam int TPM_BITS    = 24;
    localparam int WORD_BITS   = 32;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 24;

    // rpm divide widths
    localparam int NUM_BITS    = WORD_BITS + TPM_BITS;
    localparam int DEN_BITS    = WORD_BITS + CPR_BITS;
    localparam int QUO_BITS    = 31;
    localparam int HI_BITS     = NUM_BITS - QUO_BITS;
    localparam int STEP_BITS   = $clog2(QUO_BITS);

    localparam logic [CPR_BITS-1:0] CPR_RESET = CPR_BITS'(1024);
    localparam logic [TPM_BITS-1:0] TPM_RESET = TPM_BITS'(60000);
    localparam logic [QUO_BITS-1:0] RPM_MAX   = {QUO_BITS{1'b1}};

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_RPM    = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_COUNTS_PER_REV   = 1'b0,
        REG_TICKS_PER_MINUTE = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [MOTOR_BITS-1:0] motor_id;
        logic [COUNT_BITS-1:0] raw_count;
        logic                  direction;
    } in_t;

    typedef struct packed {
        logic [MOTOR_BITS-1:0]      motor_out;
        logic [QUO_BITS-1:0]        rpm;
        logic signed [WORD_BITS-1:0] position;
        logic                       sample_skipped;
        logic                       no_elapsed_time;
    } out_t;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic mul;
        logic prep;
        logic div_step;
        logic out_load;
    } ctrl_t;

    typedef struct packed {
        logic need_div;
        logic overflow;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/ecrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ecrt_ctrl
// Sequencer for the tracker: takes one item, runs the update and, when needed,
// the rpm divide, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ecrt_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ecrt_pkg::status_t status,
    output ecrt_pkg::ctrl_t        ctrl
);
    import ecrt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = status.need_div ? ST_MUL : ST_OUT;
            end
            ST_MUL: begin
                state_next = ST_PREP;
            end
            ST_PREP: begin
                state_next = status.overflow ? ST_OUT : ST_DIV;
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl    = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready        = 1'b1;
                ctrl.load_item = s_valid;
            end
            ST_EXEC:  ctrl.exec     = 1'b1;
            ST_MUL:   ctrl.mul      = 1'b1;
            ST_PREP:  ctrl.prep     = 1'b1;
            ST_DIV:   ctrl.div_step = 1'b1;
            ST_OUT:   ctrl.out_load = status.out_free;
            default: begin
                ctrl = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/ecrt_dp.sv =====
// ----------------------------------------------------------------------------
// ecrt_dp
// Datapath: per-motor counters, configuration registers, the two rpm
// products, a radix-2 restoring divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ecrt_dp (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire ecrt_pkg::in_t                       s_data,
    output ecrt_pkg::out_t                           m_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    input  wire logic                                cfg_we,
    input  wire logic [ecrt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [ecrt_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  wire ecrt_pkg::ctrl_t                     ctrl,
    output ecrt_pkg::status_t                        status
);
    import ecrt_pkg::*;

    logic [CPR_BITS-1:0]   cpr_reg;
    logic [TPM_BITS-1:0]   tpm_reg;
    in_t                   item_reg;

    logic [WORD_BITS-1:0]  tick_reg;
    logic [COUNT_BITS-1:0] last_raw_reg  [NUM_MOTORS];
    logic [WORD_BITS-1:0]  moved_tot_reg [NUM_MOTORS];
    logic [WORD_BITS-1:0]  moved_q_reg   [NUM_MOTORS];
    logic [WORD_BITS-1:0]  tick_q_reg    [NUM_MOTORS];
    logic [WORD_BITS-1:0]  pos_reg       [NUM_MOTORS];

    logic [WORD_BITS-1:0]  moved_reg;
    logic [WORD_BITS-1:0]  elapsed_reg;
    logic [NUM_BITS-1:0]   num_reg;
    logic [DEN_BITS-1:0]   den_reg;
    logic [DEN_BITS-1:0]   rem_reg;
    logic [QUO_BITS-1:0]   num_lo_reg;
    logic [QUO_BITS-1:0]   quo_reg;
    logic [STEP_BITS-1:0]  step_reg;
    logic [QUO_BITS-1:0]   rpm_reg;
    logic                  skipped_reg;
    logic                  no_time_reg;
    logic                  overflow_reg;

    out_t                  out_reg;
    logic                  out_valid_reg;

    logic [MOTOR_BITS-1:0] m;
    logic                  motor_ok;
    logic                  is_rpm;
    logic [WORD_BITS-1:0]  elapsed;
    logic [WORD_BITS-1:0]  moved;
    logic [COUNT_BITS-1:0] prev_raw;
    logic                  implausible;
    logic [COUNT_BITS:0]   diff;
    logic [COUNT_BITS:0]   delta_w;
    logic [WORD_BITS-1:0]  delta;
    logic [CPR_BITS-1:0]   cpr_eff;
    logic [HI_BITS-1:0]    num_hi;
    logic [DEN_BITS:0]     trial;
    logic [DEN_BITS:0]     trial_diff;
    logic                  trial_ge;

    assign m        = item_reg.motor_id;
    assign motor_ok = (WORD_BITS'(m) < WORD_BITS'(NUM_MOTORS));
    assign is_rpm   = (item_reg.cmd == CMD_RPM) && motor_ok;
    assign elapsed  = tick_reg - tick_q_reg[m];
    assign moved    = moved_tot_reg[m] - moved_q_reg[m];

    // wrap-corrected step magnitude
    assign prev_raw    = last_raw_reg[m];
    assign implausible = (item_reg.raw_count == {COUNT_BITS{1'b1}}) && (prev_raw == '0);
    assign diff        = (item_reg.raw_count > prev_raw)
                       ? {1'b0, item_reg.raw_count - prev_raw}
                       : {1'b0, prev_raw - item_reg.raw_count};
    assign delta_w     = (diff > (COUNT_BITS+1)'({COUNT_BITS-1{1'b1}}))
                       ? ((COUNT_BITS+1)'(1) << COUNT_BITS) - diff
                       : diff;
    assign delta       = WORD_BITS'(delta_w);

    assign cpr_eff    = (cpr_reg == '0) ? CPR_BITS'(1) : cpr_reg;
    assign num_hi     = num_reg[NUM_BITS-1:QUO_BITS];
    assign trial      = {rem_reg, num_lo_reg[QUO_BITS-1]};
    assign trial_diff = trial - {1'b0, den_reg};
    assign trial_ge   = (trial >= {1'b0, den_reg});

    assign status.need_div = is_rpm && (elapsed != '0);
    assign status.overflow = (DEN_BITS'(num_hi) >= den_reg);
    assign status.div_done = (step_reg == STEP_BITS'(QUO_BITS - 1));
    assign status.out_free = !out_valid_reg || m_ready;

    assign m_data  = out_reg;
    assign m_valid = out_valid_reg;

    // configuration and item capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpr_reg <= CPR_RESET;
            tpm_reg <= TPM_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_COUNTS_PER_REV:   cpr_reg <= cfg_data[CPR_BITS-1:0];
                REG_TICKS_PER_MINUTE: tpm_reg <= cfg_data[TPM_BITS-1:0];
                default: begin
                    cpr_reg <= cpr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_item) begin
            item_reg <= s_data;
        end
    end

    // motor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= '0;
            for (int i = 0; i < NUM_MOTORS; i++) begin
                last_raw_reg[i]  <= '0;
                moved_tot_reg[i] <= '0;
                moved_q_reg[i]   <= '0;
                tick_q_reg[i]    <= '0;
                pos_reg[i]       <= '0;
            end
        end else if (ctrl.exec) begin
            case (item_reg.cmd)
                CMD_TICK: begin
                    tick_reg <= tick_reg + WORD_BITS'(1);
                end
                CMD_SAMPLE: begin
                    if (motor_ok && !implausible) begin
                        last_raw_reg[m]  <= item_reg.raw_count;
                        moved_tot_reg[m] <= moved_tot_reg[m] + delta;
                        pos_reg[m]       <= item_reg.direction ? pos_reg[m] - delta
                                                               : pos_reg[m] + delta;
                    end
                end
                CMD_RPM: begin
                    if (motor_ok) begin
                        tick_q_reg[m]  <= tick_reg;
                        moved_q_reg[m] <= moved_tot_reg[m];
                    end
                end
                default: begin
                    tick_reg <= tick_reg;
                end
            endcase
        end
    end

    // rpm products and divider
    always_ff @(posedge aclk) begin
        if (ctrl.exec) begin
            moved_reg   <= moved;
            elapsed_reg <= elapsed;
            rpm_reg     <= '0;
            skipped_reg <= (item_reg.cmd == CMD_SAMPLE) && motor_ok && implausible;
            no_time_reg <= is_rpm && (elapsed == '0);
        end
        if (ctrl.mul) begin
            num_reg <= moved_reg * tpm_reg;
            den_reg <= cpr_eff * elapsed_reg;
        end
        if (ctrl.prep) begin
            rem_reg      <= DEN_BITS'(num_hi);
            num_lo_reg   <= num_reg[QUO_BITS-1:0];
            quo_reg      <= '0;
            step_reg     <= '0;
            overflow_reg <= status.overflow;
            if (status.overflow) begin
                rpm_reg <= RPM_MAX;
            end
        end
        if (ctrl.div_step) begin
            rem_reg    <= trial_ge ? trial_diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
            num_lo_reg <= {num_lo_reg[QUO_BITS-2:0], 1'b0};
            quo_reg    <= {quo_reg[QUO_BITS-2:0], trial_ge};
            step_reg   <= step_reg + STEP_BITS'(1);
            if (status.div_done && !overflow_reg) begin
                rpm_reg <= {quo_reg[QUO_BITS-2:0], trial_ge};
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            out_reg.motor_out       <= m;
            out_reg.rpm             <= rpm_reg;
            out_reg.position        <= motor_ok ? pos_reg[m] : '0;
            out_reg.sample_skipped  <= skipped_reg;
            out_reg.no_elapsed_time <= no_time_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/encoder_count_rpm_tracker.sv =====
// ----------------------------------------------------------------------------
// encoder_count_rpm_tracker
// Tracks encoder counts, positions and rpm of several motors.
// ----------------------------------------------------------------------------
// Input channel s_valid/s_ready/s_data carries one item: a tick, an encoder
// sample or an rpm request for one motor. Every item gives exactly one result
// on m_valid/m_ready/m_data with the motor, rpm, position and two flags.
// Configuration is written through cfg_we/cfg_index/cfg_data: index 0 counts
// per revolution, index 1 ticks per minute. The user must write it only while
// no item is in flight; the block itself does not enforce this. Ticks,
// samples and rpm requests with zero elapsed time go from the update straight
// to the output load; a saturated rpm passes a product and a setup state, and
// an rpm request that divides passes those and the 31-step bit-serial divider.
// One item is worked on at a time; s_ready returns the cycle after the
// result enters the output register, so a new item is taken while the
// previous result waits.
// When the receiver stalls, the finished result is held in the output
// register and the next item stops before its result until m_ready frees it.
// Reset clears the tick counter, all per-motor counts and the output valid,
// and restores the default configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_count_rpm_tracker (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire ecrt_pkg::in_t                       s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output ecrt_pkg::out_t                           m_data,
    input  wire logic                                cfg_we,
    input  wire logic [ecrt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [ecrt_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import ecrt_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    ecrt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .ctrl    (ctrl)
    );

    ecrt_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .status    (status)
    );

endmodule

`default_nettype wire
